FILE: rtl/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/rau_pkg.sv
// types and constants of the rational arithmetic unit
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] OP_REDUCE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_EQ     = 3'd5;
    localparam logic [2:0] OP_LT     = 3'd6;
    localparam logic [2:0] OP_GT     = 3'd7;

    localparam logic [1:0] CLS_NUM = 2'd0;
    localparam logic [1:0] CLS_INF = 2'd1;
    localparam logic [1:0] CLS_NAN = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_num;
        logic [31:0]        a_den;
        logic signed [31:0] b_num;
        logic [31:0]        b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [31:0]        res_den;
        logic               cmp_true;
        logic [1:0]         value_class;
        logic               overflow;
    } t_rau_out;
endpackage

FILE: rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: shared multiplier, binary gcd and serial divider
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall     i_in  (t_rau_in)
//   out      output     o_out_valid / i_out_stall   o_out (t_rau_out)
//
// every beat runs 3 multiply steps on one multiplier; beats other than compares and 0/0
// then run a binary gcd loop of up to about 4*WORD_BITS steps and two restoring
// divisions of 2*WORD_BITS steps
// o_in_stall is high from acceptance until the result is in the output register
// the output register lets the next beat start while a result is stalled
// synchronous active-low reset clears the sequencer and the output valid
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rau_pkg::t_rau_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rau_pkg::t_rau_out o_out
);
`include "rational_arithmetic_unit_assert.svh"

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS;
    localparam int KW = $clog2(DW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_GCD0 = 3'd3;
    localparam logic [2:0] S_GCD1 = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [DW-1:0] HALF = DW'(1) << (W - 1);

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_op;
    logic              r_sa, r_sb, r_neg, r_dsel;
    logic [W-1:0]      r_ma, r_mb, r_ad, r_bd;
    logic [1:0]        r_mstep;
    logic [DW-1:0]     r_p0, r_p1, r_p2;
    logic [DW-1:0]     r_mag, r_den, r_u, r_v, r_g, r_x, r_qm;
    logic [DW-1:0]     r_rem;
    logic [KW-1:0]     r_k, r_cnt;
    rau_pkg::t_rau_out r_res, r_out;
    logic              r_out_valid;

    logic [W-1:0]  wa, wb, ma_in, mb_in;
    logic [W-1:0]  mul_a, mul_b;
    logic [DW-1:0] prod;
    logic          sq;
    logic          c_neg;
    logic [DW-1:0] c_mag, c_den;
    rau_pkg::t_rau_out c_res;
    logic signed [DW:0] lv, rv;
    logic          cmp_t;
    logic [DW:0]   rs;
    logic          ge;
    logic [DW-1:0] x_next, nb;
    logic          ovf;
    logic          slot_free;

    assign wa    = i_in.a_num[W-1:0];
    assign wb    = i_in.b_num[W-1:0];
    assign ma_in = wa[W-1] ? (~wa + W'(1)) : wa;
    assign mb_in = wb[W-1] ? (~wb + W'(1)) : wb;

    always_comb begin
        case (r_mstep)
            2'd0: begin
                mul_a = r_ma;
                mul_b = (r_op == rau_pkg::OP_MUL) ? r_mb : r_bd;
            end
            2'd1: begin
                mul_a = r_mb;
                mul_b = r_ad;
            end
            default: begin
                mul_a = r_ad;
                mul_b = (r_op == rau_pkg::OP_DIV) ? r_mb : r_bd;
            end
        endcase
    end
    assign prod = DW'(mul_a) * DW'(mul_b);

    always_comb begin
        sq    = (r_op == rau_pkg::OP_SUB) ? ~r_sb : r_sb;
        c_neg = r_sa ^ r_sb;
        c_mag = r_p0;
        c_den = r_p2;
        case (r_op)
            rau_pkg::OP_REDUCE: begin
                c_neg = r_sa;
                c_mag = DW'(r_ma);
                c_den = DW'(r_ad);
            end
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (r_sa == sq) begin
                    c_neg = r_sa;
                    c_mag = r_p0 + r_p1;
                end else if (r_p0 >= r_p1) begin
                    c_neg = r_sa;
                    c_mag = r_p0 - r_p1;
                end else begin
                    c_neg = sq;
                    c_mag = r_p1 - r_p0;
                end
            end
            default: begin
                c_neg = r_sa ^ r_sb;
                c_mag = r_p0;
                c_den = r_p2;
            end
        endcase
    end

    always_comb begin
        lv = r_sa ? -$signed({1'b0, r_p0}) : $signed({1'b0, r_p0});
        rv = r_sb ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
        case (r_op)
            rau_pkg::OP_EQ: cmp_t = (lv == rv);
            rau_pkg::OP_LT: cmp_t = (lv < rv);
            default:        cmp_t = (lv > rv);
        endcase
    end

    always_comb begin
        c_res = '0;
        if (r_op == rau_pkg::OP_EQ || r_op == rau_pkg::OP_LT ||
            r_op == rau_pkg::OP_GT) begin
            c_res.cmp_true = cmp_t;
        end else begin
            c_res.value_class = rau_pkg::CLS_NAN;
        end
    end

    assign rs     = {r_rem, r_x[DW-1]};
    assign ge     = (rs >= {1'b0, r_g});
    assign x_next = {r_x[DW-2:0], ge};

    assign nb  = r_neg ? (~r_qm + DW'(1)) : r_qm;
    assign ovf = (r_neg ? (r_qm > HALF) : (r_qm > HALF - DW'(1))) | (|r_x[DW-1:W]);

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MUL;
            S_MUL:  if (r_mstep == 2'd2) n_state = S_COMB;
            S_COMB: begin
                if (r_op == rau_pkg::OP_EQ || r_op == rau_pkg::OP_LT ||
                    r_op == rau_pkg::OP_GT) begin
                    n_state = S_OUT;
                end else if (c_mag == '0 && c_den == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_GCD0;
                end
            end
            S_GCD0: begin
                if (r_u == '0 || r_v == '0) n_state = S_DIV;
                else if (r_u[0] || r_v[0]) n_state = S_GCD1;
            end
            S_GCD1: if (r_u == '0) n_state = S_DIV;
            S_DIV:  if (r_cnt == KW'(DW - 1) && r_dsel) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mstep     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_MUL) r_mstep <= r_mstep + 2'd1;
            else                  r_mstep <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op <= i_in.op;
                r_sa <= wa[W-1];
                r_sb <= wb[W-1];
                r_ma <= ma_in;
                r_mb <= mb_in;
                r_ad <= i_in.a_den[W-1:0];
                r_bd <= i_in.b_den[W-1:0];
            end
            S_MUL: begin
                case (r_mstep)
                    2'd0:    r_p0 <= prod;
                    2'd1:    r_p1 <= prod;
                    default: r_p2 <= prod;
                endcase
            end
            S_COMB: begin
                r_neg <= c_neg;
                r_mag <= c_mag;
                r_den <= c_den;
                r_u   <= c_mag;
                r_v   <= c_den;
                r_k   <= '0;
                r_res <= c_res;
            end
            S_GCD0, S_GCD1: begin
                if (r_u == '0 || (r_state == S_GCD0 && r_v == '0)) begin
                    r_g    <= ((r_u == '0) ? r_v : r_u) << r_k;
                    r_x    <= r_mag;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_dsel <= 1'b0;
                end else if (r_state == S_GCD0) begin
                    if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + KW'(1);
                    end
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= (r_u - r_v) >> 1;
                end else begin
                    r_v <= (r_v - r_u) >> 1;
                end
            end
            S_DIV: begin
                if (r_cnt == KW'(DW - 1) && !r_dsel) begin
                    r_qm   <= x_next;
                    r_x    <= r_den;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_dsel <= 1'b1;
                end else begin
                    r_rem <= ge ? DW'(rs - {1'b0, r_g}) : rs[DW-1:0];
                    r_x   <= x_next;
                    r_cnt <= r_cnt + KW'(1);
                end
            end
            S_FIN: begin
                r_res.res_num     <= 32'($signed(nb[W-1:0]));
                r_res.res_den     <= 32'(r_x[W-1:0]);
                r_res.cmp_true    <= 1'b0;
                r_res.value_class <= (r_x == '0) ? rau_pkg::CLS_INF : rau_pkg::CLS_NUM;
                r_res.overflow    <= ovf;
            end
            S_OUT: if (slot_free) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RAU_ASSERT_NEXT(a_start, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_MUL)
    `RAU_ASSERT_IMPLY(a_gcd_nz, i_clk, i_rst_n, r_state == S_DIV, r_g != '0)
    `RAU_ASSERT_IMPLY(a_cmp_fields, i_clk, i_rst_n, o_out_valid && o_out.cmp_true,
        o_out.res_den == '0 && o_out.value_class == rau_pkg::CLS_NUM)
    `RAU_ASSERT_IMPLY(a_nan_fields, i_clk, i_rst_n,
        o_out_valid && o_out.value_class == rau_pkg::CLS_NAN,
        o_out.res_num == '0 && o_out.res_den == '0 && !o_out.overflow)
endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the rational arithmetic unit
module tb_top;
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    rau_pkg::t_rau_in  in_beat = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    rau_pkg::t_rau_out out_beat;
    bit                in_accepted = 1'b0;

    rau_pkg::t_rau_in  pending_q[$];
    rau_pkg::t_rau_out awaited_q[$];
    int       n_err = 0;
    int       n_done = 0;
    int       n_sent = 0;
    int       send_idle_pct = 14;
    int       recv_idle_pct = 51;

    rational_arithmetic_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat)
    );

    always #5 i_clk = ~i_clk;

    function automatic rau_pkg::t_rau_out reduce_frac(bit neg, logic [63:0] mag,
                                                      logic [63:0] den);
        rau_pkg::t_rau_out r;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] nb;
        r = '0;
        x = mag;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0) begin
            r.value_class = rau_pkg::CLS_NAN;
            return r;
        end
        mag = mag / x;
        den = den / x;
        r.value_class = (den == 0) ? rau_pkg::CLS_INF : rau_pkg::CLS_NUM;
        if (neg ? (mag > 64'h8000_0000) : (mag > 64'h7fff_ffff)) r.overflow = 1'b1;
        if (den > 64'hffff_ffff) r.overflow = 1'b1;
        nb = neg ? (64'd0 - mag) : mag;
        r.res_num = nb[31:0];
        r.res_den = den[31:0];
        return r;
    endfunction

    function automatic rau_pkg::t_rau_out rational_result(rau_pkg::t_rau_in b);
        rau_pkg::t_rau_out  r;
        logic signed [63:0] an;
        logic signed [63:0] bn;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic [63:0]        ad;
        logic [63:0]        bd;
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [63:0]        p;
        logic [63:0]        q;
        bit                 sa;
        bit                 sb;
        bit                 sq;
        r = '0;
        an = b.a_num;
        bn = b.b_num;
        ad = {32'd0, b.a_den};
        bd = {32'd0, b.b_den};
        sa = an < 0;
        sb = bn < 0;
        ma = sa ? -an : an;
        mb = sb ? -bn : bn;
        case (b.op)
            rau_pkg::OP_EQ, rau_pkg::OP_LT, rau_pkg::OP_GT: begin
                lhs = an * $signed(bd);
                rhs = bn * $signed(ad);
                r.cmp_true = (b.op == rau_pkg::OP_EQ) ? (lhs == rhs) :
                             (b.op == rau_pkg::OP_LT) ? (lhs < rhs) : (lhs > rhs);
            end
            rau_pkg::OP_REDUCE: r = reduce_frac(sa, ma, ad);
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                p = ma * bd;
                q = mb * ad;
                sq = (b.op == rau_pkg::OP_SUB) ? !sb : sb;
                if (sa == sq) r = reduce_frac(sa, p + q, ad * bd);
                else if (p >= q) r = reduce_frac(sa, p - q, ad * bd);
                else r = reduce_frac(sq, q - p, ad * bd);
            end
            rau_pkg::OP_MUL: r = reduce_frac(sa != sb, ma * mb, ad * bd);
            default: r = reduce_frac(sa != sb, ma * bd, ad * mb);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        n_err++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_accepted) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rau_pkg::t_rau_out w;
        if (i_rst_n) begin
            in_accepted <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                awaited_q.push_back(rational_result(in_beat));
                n_sent++;
            end
            if (out_valid && !out_stall) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("unexpected beat", out_beat.res_num, 32'd0);
                end else begin
                    w = awaited_q.pop_front();
                    if (out_beat.res_num !== w.res_num)
                        report_mismatch("res_num", out_beat.res_num, w.res_num);
                    if (out_beat.res_den !== w.res_den)
                        report_mismatch("res_den", out_beat.res_den, w.res_den);
                    if (out_beat.cmp_true !== w.cmp_true)
                        report_mismatch("cmp_true", 32'(out_beat.cmp_true),
                                        32'(w.cmp_true));
                    if (out_beat.value_class !== w.value_class)
                        report_mismatch("value_class", 32'(out_beat.value_class),
                                        32'(w.value_class));
                    if (out_beat.overflow !== w.overflow)
                        report_mismatch("overflow", 32'(out_beat.overflow),
                                        32'(w.overflow));
                end
                n_done++;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom_range(64);
            6: return $urandom_range(5000) * ($urandom_range(12) + 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        rau_pkg::t_rau_in b;
        b.op = op;
        b.a_num = an;
        b.a_den = ad;
        b.b_num = bn;
        b.b_den = bd;
        pending_q.push_back(b);
    endtask

    task automatic wait_drain();
        while (pending_q.size() > 0 || in_valid || awaited_q.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        rau_pkg::t_rau_in b;
        logic [31:0] na;
        logic [31:0] nb;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: every op, extremes, infinities, nan, overflow
        for (int k = 0; k < 8; k++) add_beat(k[2:0], 32'd6, 32'd4, 32'hffff_fffd, 32'd9);
        add_beat(rau_pkg::OP_REDUCE, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        add_beat(rau_pkg::OP_REDUCE, 32'd0, 32'd0, 32'd0, 32'd1);
        add_beat(rau_pkg::OP_REDUCE, 32'd0, 32'd7, 32'd0, 32'd1);
        add_beat(rau_pkg::OP_REDUCE, 32'hffff_fff9, 32'd0, 32'd0, 32'd1);
        add_beat(rau_pkg::OP_ADD, 32'd5, 32'd0, 32'd3, 32'd0);
        add_beat(rau_pkg::OP_SUB, 32'd5, 32'd0, 32'd3, 32'd0);
        add_beat(rau_pkg::OP_DIV, 32'd3, 32'd2, 32'd0, 32'd5);
        add_beat(rau_pkg::OP_DIV, 32'd0, 32'd2, 32'd0, 32'd5);
        add_beat(rau_pkg::OP_DIV, 32'd3, 32'd2, 32'hffff_fffe, 32'd5);
        add_beat(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        add_beat(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        add_beat(rau_pkg::OP_MUL, 32'd1, 32'hffff_ffff, 32'd1, 32'hffff_fffd);
        add_beat(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
                 32'hffff_fffe);
        add_beat(rau_pkg::OP_EQ, 32'd0, 32'd0, 32'd5, 32'd3);
        add_beat(rau_pkg::OP_LT, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'd1);
        add_beat(rau_pkg::OP_GT, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'hffff_ffff);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 14 : 0;
            for (int k = 0; k < 200; k++) begin
                b.op = 3'($urandom_range(7));
                b.a_den = pick_word();
                b.b_den = pick_word();
                b.a_num = pick_word();
                b.b_num = pick_word();
                if ($urandom_range(3) == 0) begin
                    // shared factor so reduction really divides
                    na = $urandom_range(1000);
                    nb = $urandom_range(900) + 1;
                    b.a_num = ($urandom_range(1) ? -1 : 1) * int'(na * 6);
                    b.a_den = nb * 6;
                    b.b_den = nb * 10;
                end
                pending_q.push_back(b);
            end
            wait_drain();
        end
        repeat (600) @(posedge i_clk);
        $display("covered %0d beats over all ops, sign, zero and infinity cases", n_sent);
        $display("three stall phases, %0d results checked", n_done);
        if (n_err == 0 && awaited_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("tb_top: errors");
        $finish;
    end
endmodule
